// File: hdl/shower_top4_and_polar_energy_bins_macros.svh
// assertion helpers, all clocked on clk and quiet while rst_n is low
`ifndef SHOWER_TOP4_AND_POLAR_ENERGY_BINS_MACROS_SVH
`define SHOWER_TOP4_AND_POLAR_ENERGY_BINS_MACROS_SVH

// property must hold at every active edge
`define STPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true
`define STPB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/stpb_pkg.sv
`timescale 1ns / 1ps
package stpb_pkg;

  localparam int TOP_COUNT  = 4;
  localparam int ANGLE_BITS = 12;

  localparam int NUM_BINS    = 4;
  localparam int BIN_IDX_W   = $clog2(NUM_BINS);
  localparam int ENERGY_W    = 16;
  localparam int POLAR_W     = ANGLE_BITS + 1;
  localparam int EDGE_W      = 12;
  localparam int SUM_W       = 24;
  localparam int RANK_W      = 2;
  localparam int CNT_W       = $clog2(TOP_COUNT + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_CFG_REGS = NUM_BINS;
  localparam int CMP_W       = (ANGLE_BITS > EDGE_W) ? ANGLE_BITS : EDGE_W;
  localparam int ANGLE_PERIOD = 1 << ANGLE_BITS;
  localparam int ANGLE_HALF   = 1 << (ANGLE_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COT_3_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COT_2_5 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COT_2_0 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COT_1_5 = CFG_IDX_W'(3);

  localparam logic [EDGE_W-1:0] EDGE_RESET [NUM_BINS] = '{
    EDGE_W'(419), EDGE_W'(496), EDGE_W'(604), EDGE_W'(767)
  };

  typedef struct packed {
    logic                valid;
    logic [ENERGY_W-1:0] energy;
    logic [POLAR_W-1:0]  angle;
  } entry_t;

  // per-cycle controls shared by the cell row and the bin bank
  typedef struct packed {
    logic take;   // accepted request, not hot
    logic clear;  // accepted request closing the event
    logic load;   // copy next state into the drain row
    logic shift;  // drain row moves one place toward rank 0
  } ctl_t;

endpackage

// File: hdl/stpb_cell.sv
`timescale 1ns / 1ps
module stpb_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stpb_pkg::ctl_t                  ctl,
  input  logic [stpb_pkg::ENERGY_W-1:0]   new_energy,
  input  logic [stpb_pkg::POLAR_W-1:0]    new_angle,
  input  logic                            prev_gt,
  input  stpb_pkg::entry_t                prev_entry,
  input  stpb_pkg::entry_t                drain_in,
  output logic                            gt,
  output stpb_pkg::entry_t                held,
  output stpb_pkg::entry_t                drain_out
);
  import stpb_pkg::*;

  entry_t held_r, held_nxt;
  entry_t drain_r, drain_nxt;
  logic [ENERGY_W-1:0] held_energy;

  // an empty place compares as energy zero
  assign held_energy = held_r.valid ? held_r.energy : '0;
  assign gt          = new_energy > held_energy;

  // sorted row: if the upper neighbor also beats its entry, this place shifts down
  always_comb begin
    held_nxt = held_r;
    if (ctl.take) begin
      if (prev_gt) begin
        held_nxt = prev_entry;
      end else if (gt) begin
        held_nxt.valid  = 1'b1;
        held_nxt.energy = new_energy;
        held_nxt.angle  = new_angle;
      end
    end
  end

  always_comb begin
    drain_nxt = drain_r;
    if (ctl.load) begin
      drain_nxt = held_nxt;
    end else if (ctl.shift) begin
      drain_nxt = drain_in;
    end
  end

  // only the held valid bit is reset (and cleared when the event closes); the payload is masked by it
  always_ff @(posedge clk) begin
    held_r.energy <= held_nxt.energy;
    held_r.angle  <= held_nxt.angle;
    drain_r       <= drain_nxt;
    if (!rst_n || ctl.clear) begin
      held_r.valid <= 1'b0;
    end else begin
      held_r.valid <= held_nxt.valid;
    end
  end

  assign held      = held_r;
  assign drain_out = drain_r;

endmodule

// File: hdl/stpb_bins.sv
`timescale 1ns / 1ps
module stpb_bins (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stpb_pkg::ctl_t                  ctl,
  input  logic [stpb_pkg::ENERGY_W-1:0]   new_energy,
  input  logic [stpb_pkg::POLAR_W-1:0]    new_angle,
  input  logic [stpb_pkg::EDGE_W-1:0]     edges [stpb_pkg::NUM_BINS],
  output logic [stpb_pkg::SUM_W-1:0]      head_sum
);
  import stpb_pkg::*;

  logic [SUM_W-1:0]      sums_r  [NUM_BINS];
  logic [SUM_W-1:0]      sums_nxt [NUM_BINS];
  logic [SUM_W-1:0]      drain_r [NUM_BINS];
  logic [ANGLE_BITS-1:0] t;
  logic [ANGLE_BITS:0]   mirror;
  logic [ANGLE_BITS-1:0] folded;
  logic [NUM_BINS-1:0]   sel;
  logic                  found;
  logic [SUM_W:0]        acc;

  // fold theta onto 0..pi/2 with the period of cot
  assign t      = new_angle[ANGLE_BITS-1:0];
  assign mirror = (ANGLE_BITS+1)'(ANGLE_PERIOD) - {1'b0, t};
  assign folded = (t <= ANGLE_BITS'(ANGLE_HALF)) ? t : mirror[ANGLE_BITS-1:0];

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (!found && (CMP_W'(folded) < CMP_W'(edges[b]))) begin
        sel[b] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (sel[b]) begin
        acc = {1'b0, sums_r[b]} + (SUM_W+1)'(new_energy);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < NUM_BINS; b++) begin
      sums_nxt[b] = sums_r[b];
      if (ctl.take && sel[b]) begin
        sums_nxt[b] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        sums_r[b] <= '0;
      end
    end else begin
      for (int b = 0; b < NUM_BINS; b++) begin
        sums_r[b] <= sums_nxt[b];
      end
    end
  end

  // drain row; ranks past the last bin read zero
  always_ff @(posedge clk) begin
    for (int b = 0; b < NUM_BINS; b++) begin
      if (ctl.load) begin
        drain_r[b] <= sums_nxt[b];
      end else if (ctl.shift) begin
        drain_r[b] <= (b == NUM_BINS - 1) ? '0 : drain_r[(b + 1) % NUM_BINS];
      end
    end
  end

  assign head_sum = drain_r[0];

endmodule

// File: hdl/shower_top4_and_polar_energy_bins.sv
`timescale 1ns / 1ps
// Ranks the showers of one event by energy and sums their energy into four forward
// bins by folded polar angle. A shower request is taken every cycle; hot showers are
// skipped. The request marked event_end closes the event: the four ranked results
// (rank 0 first, rank 3 with final_result) leave on four consecutive output requests
// while the next event is already being collected. Only a second event_end arriving
// before the previous event's results have drained is held off. Configuration writes
// are taken any time the block is idle.
module shower_top4_and_polar_energy_bins (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [stpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stpb_pkg::EDGE_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stpb_pkg::ENERGY_W-1:0]   in_shower_energy,
  input  logic [stpb_pkg::POLAR_W-1:0]    in_polar_angle,
  input  logic                            in_hot_flag,
  input  logic                            in_event_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stpb_pkg::RANK_W-1:0]     out_rank,
  output logic [stpb_pkg::ENERGY_W-1:0]   out_ranked_energy,
  output logic [stpb_pkg::POLAR_W-1:0]    out_ranked_angle,
  output logic                            out_rank_present,
  output logic [stpb_pkg::SUM_W-1:0]      out_bin_energy_sum,
  output logic                            out_final_result
);
  import stpb_pkg::*;
  `include "shower_top4_and_polar_energy_bins_macros.svh"

  logic [EDGE_W-1:0]    edges_r [NUM_BINS];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic                 in_acc, out_acc, drain_busy;
  ctl_t                 ctl;
  logic [TOP_COUNT-1:0] gt;
  entry_t               held  [TOP_COUNT];
  entry_t               drain [TOP_COUNT];
  logic [TOP_COUNT-1:0] held_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) begin
        edges_r[b] <= EDGE_RESET[b];
      end
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS))) begin
      edges_r[cfg_index[BIN_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  assign out_acc    = out_valid && !out_stall;
  assign drain_busy = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_stall   = in_event_end && drain_busy;
  assign in_acc     = in_valid && !in_stall;

  assign ctl.take  = in_acc && !in_hot_flag;
  assign ctl.clear = in_acc && in_event_end;
  assign ctl.load  = ctl.clear;
  assign ctl.shift = out_acc;

  always_comb begin
    cnt_nxt  = cnt_r;
    rank_nxt = rank_r;
    if (ctl.load) begin
      cnt_nxt  = CNT_W'(TOP_COUNT);
      rank_nxt = '0;
    end else if (out_acc) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      rank_nxt = rank_r + RANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rank_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      rank_r <= rank_nxt;
    end
  end

  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_cell
    logic   prev_gt;
    entry_t prev_entry;
    entry_t drain_in;
    if (k == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_rest
      assign prev_gt    = gt[k-1];
      assign prev_entry = held[k-1];
    end
    if (k == TOP_COUNT - 1) begin : g_last
      assign drain_in = '0;
    end else begin : g_mid
      assign drain_in = drain[k+1];
    end
    stpb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_energy (in_shower_energy),
      .new_angle  (in_polar_angle),
      .prev_gt    (prev_gt),
      .prev_entry (prev_entry),
      .drain_in   (drain_in),
      .gt         (gt[k]),
      .held       (held[k]),
      .drain_out  (drain[k])
    );
    assign held_valid[k] = held[k].valid;
  end

  stpb_bins u_bins (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .new_energy (in_shower_energy),
    .new_angle  (in_polar_angle),
    .edges      (edges_r),
    .head_sum   (out_bin_energy_sum)
  );

  assign out_valid         = (cnt_r != '0);
  assign out_rank          = rank_r;
  assign out_rank_present  = drain[0].valid;
  assign out_ranked_energy = drain[0].valid ? drain[0].energy : '0;
  assign out_ranked_angle  = drain[0].valid ? drain[0].angle : '0;
  assign out_final_result  = (cnt_r == CNT_W'(1));

  // occupied ranks always form a prefix of the row
  `STPB_ASSERT(a_valid_prefix, (held_valid & (held_valid + TOP_COUNT'(1))) == '0, "rank gap")
  // a new event is only handed to the drain row once the old one has left or its last rank is taken in the same cycle
  `STPB_ASSERT(a_load_free, ctl.load |-> (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_acc), "drain overrun")
  // after the last rank is taken, output goes quiet unless another event closed
  `STPB_ASSERT(a_final_quiet, (out_acc && out_final_result && !ctl.load) |=> !out_valid, "extra result")

endmodule
